@@ rtl/stq_pkg.sv @@
// shared types, codes and constants for the sorted timeout queue
package stq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam logic [31:0] FreqReset  = 32'd62500000;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_EXPIRE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WALK,
    S_INS_PUT,
    S_POP_FRONT,
    S_POP_NEXT,
    S_MUL,
    S_RESP
  } stq_state_e;

  typedef struct packed {
    logic        operation;
    logic [31:0] now_seconds;
    logic [15:0] delay_seconds;
    logic [15:0] message_tag;
  } stq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        reload_valid;
    logic [47:0] reload_ticks;
    logic        timer_disable;
    logic        fired_valid;
    logic [15:0] fired_tag;
  } stq_out_t;

  typedef struct packed {
    logic [32:0] deadline;
    logic [15:0] tag;
  } stq_entry_t;

  typedef struct packed {
    logic        go;
    logic [15:0] secs;
  } stq_mul_req_t;

endpackage

@@ rtl/stq_mem.sv @@
// entry memory: one write port, one read port with registered read data
module stq_mem #(
  parameter int unsigned DEPTH = stq_pkg::QueueDepth,
  localparam int unsigned IDXW = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IDXW-1:0]     waddr_i,
  input  stq_pkg::stq_entry_t wdata_i,
  input  logic [IDXW-1:0]     raddr_i,
  output stq_pkg::stq_entry_t rdata_o
);

  stq_pkg::stq_entry_t mem_q [DEPTH];
  stq_pkg::stq_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/stq_reload.sv @@
// reload tick multiplier: frequency times seconds, registered
module stq_reload (
  input  logic                  clk_i,
  input  stq_pkg::stq_mul_req_t req_i,
  input  logic [31:0]           freq_i,
  output logic [47:0]           ticks_o
);

  logic [47:0] ticks_d;
  logic [47:0] ticks_q;

  always_comb begin
    ticks_d = {16'b0, freq_i} * {32'b0, req_i.secs};
  end

  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      ticks_q <= ticks_d;
    end
  end

  assign ticks_o = ticks_q;

endmodule

@@ rtl/stq_ctrl.sv @@
// sequencer: circular sorted queue in memory, insertion walk from the back, pop at the head
module stq_ctrl #(
  parameter int unsigned DEPTH = stq_pkg::QueueDepth,
  localparam int unsigned IDXW = $clog2(DEPTH),
  localparam int unsigned CNTW = $clog2(DEPTH + 1),
  localparam int unsigned SW   = IDXW + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  stq_pkg::stq_in_t      item_i,
  output logic                  busy_o,
  output logic                  done_o,
  output stq_pkg::stq_out_t     result_o,
  output logic                  mem_we_o,
  output logic [IDXW-1:0]       mem_waddr_o,
  output stq_pkg::stq_entry_t   mem_wdata_o,
  output logic [IDXW-1:0]       mem_raddr_o,
  input  stq_pkg::stq_entry_t   mem_rdata_i,
  output stq_pkg::stq_mul_req_t mul_o,
  input  logic [47:0]           ticks_i
);

  stq_pkg::stq_state_e state_d, state_q;
  logic [IDXW-1:0] head_d, head_q;
  logic [CNTW-1:0] count_d, count_q;
  logic [CNTW-1:0] idx_d, idx_q;
  logic [31:0]     now_d, now_q;
  logic [32:0]     dl_d, dl_q;
  logic [15:0]     delay_d, delay_q;
  logic [15:0]     tag_d, tag_q;
  logic [15:0]     secs_d, secs_q;
  logic [1:0]      status_d, status_q;
  logic            rvalid_d, rvalid_q;
  logic            disable_d, disable_q;
  logic            fvalid_d, fvalid_q;
  logic [15:0]     ftag_d, ftag_q;
  logic            accept;
  logic            full;
  logic            shift_up;
  logic [32:0]     diff;
  logic [15:0]     rem_sat;

  // logical position in the queue to memory address
  function automatic logic [IDXW-1:0] phys(input logic [IDXW-1:0] base,
                                           input logic [CNTW-1:0] ofs);
    logic [SW-1:0] sum;
    sum = {1'b0, base} + SW'(ofs);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[IDXW-1:0];
  endfunction

  assign accept   = start_i && (state_q == stq_pkg::S_IDLE);
  assign full     = (count_q == CNTW'(DEPTH));
  assign shift_up = (dl_q < mem_rdata_i.deadline);

  // remaining time of the new front, overdue clamps to zero, saturate to 16 bits
  always_comb begin
    diff = '0;
    if (mem_rdata_i.deadline > {1'b0, now_q}) begin
      diff = mem_rdata_i.deadline - {1'b0, now_q};
    end
    rem_sat = (|diff[32:16]) ? 16'hFFFF : diff[15:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      stq_pkg::S_IDLE: begin
        if (accept) begin
          if (item_i.operation == stq_pkg::OP_ADD) begin
            if (full) begin
              state_d = stq_pkg::S_RESP;
            end else if (count_q == '0) begin
              state_d = stq_pkg::S_INS_PUT;
            end else begin
              state_d = stq_pkg::S_INS_WALK;
            end
          end else begin
            state_d = (count_q == '0) ? stq_pkg::S_RESP : stq_pkg::S_POP_FRONT;
          end
        end
      end
      stq_pkg::S_INS_WALK: begin
        if (!shift_up || idx_q == '0) begin
          state_d = stq_pkg::S_INS_PUT;
        end
      end
      stq_pkg::S_INS_PUT: begin
        state_d = (idx_q == '0) ? stq_pkg::S_MUL : stq_pkg::S_RESP;
      end
      stq_pkg::S_POP_FRONT: begin
        state_d = (count_q == '0) ? stq_pkg::S_RESP : stq_pkg::S_POP_NEXT;
      end
      stq_pkg::S_POP_NEXT: state_d = stq_pkg::S_MUL;
      stq_pkg::S_MUL:      state_d = stq_pkg::S_RESP;
      stq_pkg::S_RESP:     state_d = stq_pkg::S_IDLE;
      default:             state_d = stq_pkg::S_IDLE;
    endcase
  end

  // outputs: memory port, multiplier request, handshake
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = phys(head_q, idx_q);
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = head_q;
    mul_o.go    = 1'b0;
    mul_o.secs  = secs_q;
    busy_o      = (state_q != stq_pkg::S_IDLE);
    done_o      = (state_q == stq_pkg::S_RESP);
    case (state_q)
      stq_pkg::S_IDLE: begin
        if (item_i.operation == stq_pkg::OP_ADD) begin
          mem_raddr_o = phys(head_q, CNTW'(count_q - CNTW'(1)));
        end
      end
      stq_pkg::S_INS_WALK: begin
        // move the later entry up one place, and fetch the one below
        mem_we_o    = shift_up;
        mem_waddr_o = phys(head_q, CNTW'(idx_q + CNTW'(1)));
        mem_raddr_o = phys(head_q, CNTW'(idx_q - CNTW'(1)));
      end
      stq_pkg::S_INS_PUT: begin
        mem_we_o          = 1'b1;
        mem_wdata_o.deadline = dl_q;
        mem_wdata_o.tag      = tag_q;
      end
      stq_pkg::S_POP_FRONT: begin
        mem_raddr_o = phys(head_q, CNTW'(1));
      end
      stq_pkg::S_MUL: begin
        mul_o.go = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    idx_d     = idx_q;
    now_d     = now_q;
    dl_d      = dl_q;
    delay_d   = delay_q;
    tag_d     = tag_q;
    secs_d    = secs_q;
    status_d  = status_q;
    rvalid_d  = rvalid_q;
    disable_d = disable_q;
    fvalid_d  = fvalid_q;
    ftag_d    = ftag_q;
    case (state_q)
      stq_pkg::S_IDLE: begin
        if (accept) begin
          now_d     = item_i.now_seconds;
          dl_d      = {1'b0, item_i.now_seconds} + {17'b0, item_i.delay_seconds};
          delay_d   = item_i.delay_seconds;
          tag_d     = item_i.message_tag;
          status_d  = stq_pkg::STATUS_OK;
          rvalid_d  = 1'b0;
          disable_d = 1'b0;
          fvalid_d  = 1'b0;
          ftag_d    = '0;
          idx_d     = '0;
          if (item_i.operation == stq_pkg::OP_ADD) begin
            if (full) begin
              status_d = stq_pkg::STATUS_FULL;
            end else begin
              count_d = CNTW'(count_q + CNTW'(1));
              if (count_q != '0) begin
                idx_d = CNTW'(count_q - CNTW'(1));
              end
            end
          end else begin
            if (count_q == '0) begin
              status_d = stq_pkg::STATUS_EMPTY;
            end else begin
              count_d = CNTW'(count_q - CNTW'(1));
            end
          end
        end
      end
      stq_pkg::S_INS_WALK: begin
        if (!shift_up) begin
          idx_d = CNTW'(idx_q + CNTW'(1));
        end else if (idx_q != '0) begin
          idx_d = CNTW'(idx_q - CNTW'(1));
        end
      end
      stq_pkg::S_INS_PUT: begin
        if (idx_q == '0) begin
          rvalid_d = 1'b1;
          secs_d   = delay_q;
        end
      end
      stq_pkg::S_POP_FRONT: begin
        fvalid_d = 1'b1;
        ftag_d   = mem_rdata_i.tag;
        head_d   = phys(head_q, CNTW'(1));
        if (count_q == '0) begin
          disable_d = 1'b1;
        end
      end
      stq_pkg::S_POP_NEXT: begin
        rvalid_d = 1'b1;
        secs_d   = rem_sat;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stq_pkg::S_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    now_q     <= now_d;
    dl_q      <= dl_d;
    delay_q   <= delay_d;
    tag_q     <= tag_d;
    secs_q    <= secs_d;
    status_q  <= status_d;
    rvalid_q  <= rvalid_d;
    disable_q <= disable_d;
    fvalid_q  <= fvalid_d;
    ftag_q    <= ftag_d;
  end

  always_comb begin
    result_o.status        = status_q;
    result_o.reload_valid  = rvalid_q;
    result_o.reload_ticks  = rvalid_q ? ticks_i : '0;
    result_o.timer_disable = disable_q;
    result_o.fired_valid   = fvalid_q;
    result_o.fired_tag     = ftag_q;
  end

endmodule

@@ rtl/sorted_timeout_queue.sv @@
// top level of the sorted timeout queue
//
// Command channel: drive item_i and raise start; the item is taken at a rising
// edge where start is high and busy is low. busy stays high until the result
// has been shown. Each item gives exactly one result on result_o, marked by done_o
// for a single cycle; the receiver cannot stall, so it must take it then.
// Steps from the accepting edge to the done_o cycle:
//   add on a full queue, expire on an empty queue: straight to the result
//   add: walks k entries from the back (k <= entries held), then writes the
//        new entry, plus the multiply when the new entry becomes the front
//   expire: pops the front; when entries remain, fetches the new front and multiplies
// One item is in flight at a time and busy drops the cycle after done_o, so the
// next item is taken only after the result of the last. The insertion walk, one
// memory entry per cycle through the single read port, sets the worst case: a
// new front ahead of QUEUE_DEPTH - 1 entries.
// cfg_we_i writes the counter frequency from cfg_wdata_i; write it only while idle.
// Reset empties the queue and restores the frequency to its default; the entry
// memory needs no clearing since only occupied entries are ever used.
module sorted_timeout_queue #(
  parameter int unsigned QUEUE_DEPTH = stq_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  stq_pkg::stq_in_t  item_i,
  output logic              done_o,
  output stq_pkg::stq_out_t result_o,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i
);

  localparam int unsigned IDXW = $clog2(QUEUE_DEPTH);

  logic [31:0]           freq_q;
  logic [31:0]           freq_d;
  logic                  mem_we;
  logic [IDXW-1:0]       mem_waddr;
  stq_pkg::stq_entry_t   mem_wdata;
  logic [IDXW-1:0]       mem_raddr;
  stq_pkg::stq_entry_t   mem_rdata;
  stq_pkg::stq_mul_req_t mul_req;
  logic [47:0]           ticks;

  assign freq_d = cfg_we_i ? cfg_wdata_i : freq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= stq_pkg::FreqReset;
    end else begin
      freq_q <= freq_d;
    end
  end

  stq_ctrl #(
    .DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .item_i      (item_i),
    .busy_o      (busy),
    .done_o      (done_o),
    .result_o    (result_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mul_o       (mul_req),
    .ticks_i     (ticks)
  );

  stq_mem #(
    .DEPTH(QUEUE_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  stq_reload u_reload (
    .clk_i   (clk_i),
    .req_i   (mul_req),
    .freq_i  (freq_q),
    .ticks_o (ticks)
  );

endmodule

@@ rtl/stq_checker.sv @@
// port-level checks for the sorted timeout queue, bound to the top level
module stq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_i,
  input logic              done_i,
  input stq_pkg::stq_out_t result_i
);

  // a result only comes while an item is in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> busy_i)
    else $error("result strobe while idle");

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i) |=> busy_i)
    else $error("accepted item did not make the block busy");

  // the block frees up right after the result
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |=> !busy_i)
    else $error("block still busy after result");

  // a rejected item changes nothing and reports nothing else
  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && result_i.status != stq_pkg::STATUS_OK) |->
      (!result_i.reload_valid && !result_i.fired_valid && !result_i.timer_disable))
    else $error("rejected item carries a side effect");

  // counter is never both reloaded and switched off
  a_reload_xor_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> !(result_i.reload_valid && result_i.timer_disable))
    else $error("reload and disable together");

endmodule

bind sorted_timeout_queue stq_checker u_stq_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start),
  .busy_i   (busy),
  .done_i   (done_o),
  .result_i (result_o)
);

@@ dv/tb_sorted_timeout_queue.sv @@
// testbench for the sorted timeout queue: directed and random items checked against a predictor
`timescale 1ns / 100ps

module tb_sorted_timeout_queue;

  localparam int unsigned StallLimit   = 5000;
  // idle margin before a frequency write and at the end of the run
  localparam int unsigned SettleCycles = 2 * stq_pkg::QueueDepth;
  localparam int unsigned PhaseCount   = 6;
  localparam int unsigned PhaseItems   = 250;

  class deadline_scoreboard;
    logic [32:0] deadlines [stq_pkg::QueueDepth];
    logic [15:0] tags [stq_pkg::QueueDepth];
    int unsigned entries;
    logic [31:0] freq;
    stq_pkg::stq_out_t expected_results [$];
    int unsigned errors;

    function new();
      entries = 0;
      freq    = stq_pkg::FreqReset;
      errors  = 0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function logic [47:0] ticks_for(input logic [15:0] secs);
      logic [63:0] prod;
      prod = 64'(freq) * 64'(secs);
      return prod[47:0];
    endfunction

    function void note_item(input stq_pkg::stq_in_t it);
      stq_pkg::stq_out_t res;
      logic [32:0] dl;
      logic [32:0] rem;
      int unsigned pos;
      int unsigned i;
      res = '0;
      if (it.operation == stq_pkg::OP_ADD) begin
        if (entries >= stq_pkg::QueueDepth) begin
          res.status = stq_pkg::STATUS_FULL;
        end else begin
          dl  = {1'b0, it.now_seconds} + 33'(it.delay_seconds);
          pos = 0;
          // new entry goes behind equal deadlines
          while (pos < entries && deadlines[pos] <= dl) pos++;
          for (i = entries; i > pos; i--) begin
            deadlines[i] = deadlines[i-1];
            tags[i]      = tags[i-1];
          end
          deadlines[pos] = dl;
          tags[pos]      = it.message_tag;
          entries++;
          if (pos == 0) begin
            res.reload_valid = 1'b1;
            res.reload_ticks = ticks_for(it.delay_seconds);
          end
        end
      end else begin
        if (entries == 0) begin
          res.status = stq_pkg::STATUS_EMPTY;
        end else begin
          res.fired_valid = 1'b1;
          res.fired_tag   = tags[0];
          for (i = 1; i < entries; i++) begin
            deadlines[i-1] = deadlines[i];
            tags[i-1]      = tags[i];
          end
          entries--;
          if (entries > 0) begin
            rem = '0;
            if (deadlines[0] > {1'b0, it.now_seconds}) begin
              rem = deadlines[0] - {1'b0, it.now_seconds};
            end
            if (rem > 33'hFFFF) rem = 33'hFFFF;
            res.reload_valid = 1'b1;
            res.reload_ticks = ticks_for(rem[15:0]);
          end else begin
            res.timer_disable = 1'b1;
          end
        end
      end
      expected_results.push_back(res);
    endfunction

    function void check_result(input stq_pkg::stq_out_t got);
      stq_pkg::stq_out_t want;
      logic     bad;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: status=%0d fired=%0b/%0h", got.status,
                                   got.fired_valid, got.fired_tag);
        return;
      end
      want = expected_results.pop_front();
      bad  = (got.status !== want.status) || (got.reload_valid !== want.reload_valid) ||
             (got.reload_ticks !== want.reload_ticks) ||
             (got.timer_disable !== want.timer_disable) ||
             (got.fired_valid !== want.fired_valid) || (got.fired_tag !== want.fired_tag);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected status=%0d reload=%0b/%0h disable=%0b fired=%0b/%0h",
                   want.status, want.reload_valid, want.reload_ticks, want.timer_disable,
                   want.fired_valid, want.fired_tag);
          $display("          got      status=%0d reload=%0b/%0h disable=%0b fired=%0b/%0h",
                   got.status, got.reload_valid, got.reload_ticks, got.timer_disable,
                   got.fired_valid, got.fired_tag);
        end
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  stq_pkg::stq_in_t  item_i;
  logic              done_o;
  stq_pkg::stq_out_t result_o;
  logic              cfg_we_i;
  logic [31:0]       cfg_wdata_i;

  deadline_scoreboard sb;
  logic [31:0] sys_now;
  int unsigned add_pct;
  int unsigned stall_cycles;

  sorted_timeout_queue u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(result_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("tb_sorted_timeout_queue: done, errors");
      $finish;
    end
  end

  function automatic stq_pkg::stq_in_t make_item(input logic op, input logic [31:0] now,
                                                 input logic [15:0] delay,
                                                 input logic [15:0] tag);
    stq_pkg::stq_in_t it;
    it.operation     = op;
    it.now_seconds   = now;
    it.delay_seconds = delay;
    it.message_tag   = tag;
    return it;
  endfunction

  // mostly a clock that moves forward, with expiries near the front deadline
  function automatic stq_pkg::stq_in_t next_random_item();
    stq_pkg::stq_in_t it;
    it.message_tag = $urandom_range(0, 16'hFFFF);
    if ($urandom_range(0, 99) < 20) begin
      it.operation     = ($urandom_range(0, 1) != 0) ? stq_pkg::OP_EXPIRE : stq_pkg::OP_ADD;
      it.now_seconds   = $urandom;
      it.delay_seconds = $urandom_range(0, 16'hFFFF);
    end else begin
      sys_now += $urandom_range(0, 3);
      it.delay_seconds = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16'hFFFF)
                                                      : $urandom_range(0, 300);
      it.now_seconds   = sys_now;
      if ($urandom_range(0, 99) < add_pct) begin
        it.operation = stq_pkg::OP_ADD;
      end else begin
        it.operation = stq_pkg::OP_EXPIRE;
        if (sb.entries > 0) begin
          it.now_seconds = sb.deadlines[0][31:0] + $urandom_range(0, 5) - 2;
          sys_now        = it.now_seconds;
        end
      end
    end
    return it;
  endfunction

  task automatic send_item(input stq_pkg::stq_in_t it);
    item_i <= it;
    start  <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_item(it);
  endtask

  task automatic write_frequency(input logic [31:0] value);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.freq = value;
  endtask

  initial begin
    logic [31:0] phase_freq [PhaseCount];
    int unsigned i;
    int unsigned p;
    int unsigned n;
    rst_ni       = 1'b0;
    start        = 1'b0;
    item_i       = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    sys_now      = '0;
    add_pct      = 50;
    sb = new();
    phase_freq = '{32'd1, 32'hFFFF_FFFF, 32'd0, stq_pkg::FreqReset, 32'd0, 32'd0};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(make_item(stq_pkg::OP_EXPIRE, 32'd0, 16'd0, 16'd0));
    send_item(make_item(stq_pkg::OP_ADD, 32'd0, 16'd0, 16'd0));
    send_item(make_item(stq_pkg::OP_EXPIRE, 32'd0, 16'd0, 16'd0));
    // deadline carries into the top bit
    send_item(make_item(stq_pkg::OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    send_item(make_item(stq_pkg::OP_ADD, 32'd100, 16'd5, 16'h1234));
    send_item(make_item(stq_pkg::OP_ADD, 32'd100, 16'd5, 16'h5678));
    // next front already overdue
    send_item(make_item(stq_pkg::OP_EXPIRE, 32'd200, 16'hFFFF, 16'hFFFF));
    // clock behind the front by far more than the remainder can hold
    send_item(make_item(stq_pkg::OP_EXPIRE, 32'd0, 16'h0, 16'h0));
    send_item(make_item(stq_pkg::OP_EXPIRE, 32'hFFFF_FFFF, 16'h0, 16'h0));
    for (i = 0; i < stq_pkg::QueueDepth; i++) begin
      send_item(make_item(stq_pkg::OP_ADD, 32'd1000, 16'((i * 7919) % 4000), 16'(i)));
    end
    send_item(make_item(stq_pkg::OP_ADD, 32'd1000, 16'd1, 16'hBEEF));
    start <= 1'b0;

    for (p = 0; p < PhaseCount; p++) begin
      if (p >= 4) begin
        phase_freq[p] = $urandom;
        if (phase_freq[p] == 0) phase_freq[p] = 32'd1;
      end
      write_frequency(phase_freq[p]);
      sys_now = $urandom;
      for (n = 0; n < PhaseItems; n++) begin
        if (n % 50 == 0) begin
          case ($urandom_range(0, 3))
            0: add_pct = 25;
            1: add_pct = 50;
            2: add_pct = 75;
            default: add_pct = 95;
          endcase
        end
        // phase two runs without any gaps
        if (p != 2 && $urandom_range(0, 99) < 33) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 20)) @(posedge clk_i);
        end
        send_item(next_random_item());
      end
      start <= 1'b0;
    end

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_sorted_timeout_queue: done, clean");
    end else begin
      $display("tb_sorted_timeout_queue: done, errors");
    end
    $finish;
  end

endmodule
